[hw/rtl/tcw_pkg.sv]
// shared constants and types for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int POS_W = $clog2(CELL_COUNT);
    localparam int CNT_W = $clog2(CELL_COUNT + 1);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    localparam int CELL_W = 16;
    localparam int IDX_W  = 11;

    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
    localparam logic [7:0]        NEWLINE_CODE = 8'd10;

    typedef logic [1:0] t_op;
    localparam t_op OP_PUT   = 2'd0;
    localparam t_op OP_CLEAR = 2'd1;
    localparam t_op OP_READ  = 2'd2;

endpackage

[hw/rtl/tcw_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/text_console_writer.sv]
// text console writer: cell memory, cursor, scroll and clear sequencing
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_op, i_char_code, i_color, i_cell_index
//  out     | output    | o_out_valid / i_out_ready   | o_cursor_pos, o_cell_data
//
// a put or an unused op goes from accept through the execute and finish states to the
// output register; a read in range adds the read wait state for its ram read. a put that
// moves past the bottom row streams a ram copy of each cell below the top row one row up,
// one cell a cycle through the single write port, then a blank fill of the last row.
// a clear blanks every cell, one cell a cycle; reset blanks them too with o_in_ready low.
// a new request is taken while a result waits; the next result waits for the output register.
`timescale 1ns / 1ps

module text_console_writer
    import tcw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_char_code,
    input  logic [7:0]           i_color,
    input  logic [IDX_W-1:0]     i_cell_index,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [IDX_W-1:0]     o_cursor_pos,
    output logic [CELL_W-1:0]    o_cell_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [POS_W-1:0] LAST_LINE = POS_W'(CELL_COUNT - COLUMNS);

    logic [2:0]        r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_addr, n_addr;
    logic              r_report, n_report;
    logic              r_copy_vld, n_copy_vld;
    logic [POS_W-1:0]  r_copy_dst, n_copy_dst;
    t_op               r_op;
    logic [7:0]        r_char;
    logic [7:0]        r_color;
    logic [IDX_W-1:0]  r_idx;
    logic [CELL_W-1:0] r_data, n_data;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_pos;
    logic [CELL_W-1:0] r_out_data;

    logic              ram_we;
    logic [POS_W-1:0]  ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [POS_W-1:0]  ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic in_acc;
    logic out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_pos      = r_pos;
        n_addr     = r_addr;
        n_report   = r_report;
        n_copy_vld = 1'b0;
        n_copy_dst = r_copy_dst;
        n_data     = r_data;
        ram_we     = 1'b0;
        ram_waddr  = r_pos;
        ram_wdata  = {r_color, r_char};
        ram_raddr  = POS_W'(r_idx);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_data  = '0;
                n_state = S_FIN;
                if (r_op == OP_PUT) begin
                    if (r_char != NEWLINE_CODE) begin
                        ram_we = 1'b1;
                    end
                    if (r_char == NEWLINE_CODE || r_col == LAST_COL) begin
                        n_col = '0;
                        if (r_row == LAST_ROW) begin
                            n_pos      = LAST_LINE;
                            n_addr     = CNT_W'(COLUMNS);
                            n_state    = S_SCROLL;
                        end else begin
                            n_row = r_row + 1'b1;
                            // newline or a wrap at the last column goes back by the column then down a full row
                            n_pos = r_pos - POS_W'(r_col) + POS_W'(COLUMNS);
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                        n_pos = r_pos + 1'b1;
                    end
                end else if (r_op == OP_CLEAR) begin
                    n_col    = '0;
                    n_row    = '0;
                    n_pos    = '0;
                    n_addr   = '0;
                    n_report = 1'b1;
                    n_state  = S_FILL;
                end else if (r_op == OP_READ) begin
                    if (32'(r_idx) < CELL_COUNT) begin
                        n_state = S_RDWAIT;
                    end
                end
            end
            S_RDWAIT: begin
                n_data  = ram_rdata;
                n_state = S_FIN;
            end
            S_SCROLL: begin
                // read one row ahead, write the previous read one row up
                ram_raddr = r_addr[POS_W-1:0];
                ram_we    = r_copy_vld;
                ram_waddr = r_copy_dst;
                ram_wdata = ram_rdata;
                if (r_addr != CNT_W'(CELL_COUNT)) begin
                    n_copy_vld = 1'b1;
                    n_copy_dst = POS_W'(r_addr - CNT_W'(COLUMNS));
                    n_addr     = r_addr + 1'b1;
                end else begin
                    n_addr   = CNT_W'(CELL_COUNT - COLUMNS);
                    n_report = 1'b1;
                    n_state  = S_FILL;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[POS_W-1:0];
                ram_wdata = BLANK_CELL;
                n_addr    = r_addr + 1'b1;
                if (r_addr == CNT_W'(CELL_COUNT - 1)) begin
                    n_state = r_report ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_col       <= '0;
            r_row       <= '0;
            r_pos       <= '0;
            r_addr      <= '0;
            r_report    <= 1'b0;
            r_copy_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_pos      <= n_pos;
            r_addr     <= n_addr;
            r_report   <= n_report;
            r_copy_vld <= n_copy_vld;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_copy_dst <= n_copy_dst;
        r_data     <= n_data;
        if (in_acc) begin
            r_op    <= i_op;
            r_char  <= i_char_code;
            r_color <= i_color;
            r_idx   <= i_cell_index;
        end
        if (out_load) begin
            r_out_pos  <= IDX_W'(n_pos);
            r_out_data <= r_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_out_pos;
    assign o_cell_data  = r_out_data;

    // linear position tracks row and column
    a_pos_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) == 32'(r_row) * COLUMNS + 32'(r_col))
        else $error("cursor position out of step with row and column");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS))
        else $error("cursor outside the screen");

    // scroll copy never writes the cell it reads in the same cycle
    a_scroll_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && ram_we) |-> (ram_waddr != ram_raddr))
        else $error("scroll copy read and write collide");

    // a request is always followed by its execute cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !out_load)
        else $error("pending result overwritten");

endmodule
